// ----- hdl/cmap_pkg.sv -----
// ============================================================================
// cmap_pkg
// Shared types, codes and helpers for the colormap interpolating lookup.
// ============================================================================
package cmap_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int SAMPLE_W            = 24;
    localparam int COUNT_W             = 11;
    localparam int FRAC_W              = 16;
    localparam int DIV_BITS            = 4;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 24;
    localparam int RGB_W               = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAX   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] RANGE_MIN_RESET   = -24'sd3294199;
    localparam logic signed [SAMPLE_W-1:0] RANGE_MAX_RESET   = 24'sd3294199;
    localparam logic [COUNT_W-1:0]         ENTRY_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic                       cmd;
        logic [9:0]                 entry_index;
        logic [7:0]                 entry_red;
        logic [7:0]                 entry_green;
        logic [7:0]                 entry_blue;
        logic signed [SAMPLE_W-1:0] sample_value;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       zero_range;
    } rsp_t;

    // what travels alongside the arithmetic
    typedef struct packed {
        logic       cmd;
        logic [9:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic       zero_range;
    } side_t;

    // (l*(1-f) + r*f) rounded, f in 0.16
    function automatic logic [7:0] blend(input logic [7:0] l, input logic [7:0] r,
                                         input logic [FRAC_W-1:0] f);
        logic [24:0] acc;
        acc = 25'(l) * 25'(17'h10000 - {1'b0, f}) + 25'(r) * 25'(f) + 25'(17'h08000);
        return acc[23:16];
    endfunction

endpackage

// ----- hdl/cmap_ram.sv -----
// ============================================================================
// cmap_ram
// Generic RAM, one write port, two registered read ports.
// ============================================================================
module cmap_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ----- hdl/cmap_norm.sv -----
// ============================================================================
// cmap_norm
// Offset, range check, entry count clamp and scale; selects the divider
// operands so the quotient alone gives the table position.
// ============================================================================
module cmap_norm #(
    parameter int TABLE_DEPTH = cmap_pkg::TABLE_DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int NW = cmap_pkg::SAMPLE_W + AW,
    localparam int CW = (AW + 1 > cmap_pkg::COUNT_W) ? AW + 1 : cmap_pkg::COUNT_W
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  req_valid,
    input  cmap_pkg::req_t                        req,
    input  logic signed [cmap_pkg::SAMPLE_W-1:0]  range_min,
    input  logic signed [cmap_pkg::SAMPLE_W-1:0]  range_max,
    input  logic [cmap_pkg::COUNT_W-1:0]          entry_count,
    output logic                                  norm_valid,
    output cmap_pkg::side_t                       norm_side,
    output logic [NW-1:0]                         norm_num,
    output logic [cmap_pkg::SAMPLE_W-1:0]         norm_den
);

    logic signed [cmap_pkg::SAMPLE_W:0] d;
    logic signed [cmap_pkg::SAMPLE_W:0] r;
    logic                               zero;
    logic                               in_range;
    logic [cmap_pkg::SAMPLE_W-1:0]      ad;
    logic [cmap_pkg::SAMPLE_W-1:0]      ar;
    logic [CW-1:0]                      ec;
    logic [CW-1:0]                      ec_clamped;
    logic [AW-1:0]                      em1;
    cmap_pkg::side_t                    side_next;

    logic                               a_valid_reg;
    cmap_pkg::side_t                    a_side_reg;
    logic [cmap_pkg::SAMPLE_W-1:0]      a_ad_reg;
    logic [cmap_pkg::SAMPLE_W-1:0]      a_ar_reg;
    logic [AW-1:0]                      a_em1_reg;
    logic                               a_in_range_reg;

    logic [NW-1:0]                      prod;
    logic                               sat;
    logic [NW-1:0]                      num_next;
    logic [cmap_pkg::SAMPLE_W-1:0]      den_next;

    logic                               b_valid_reg;
    cmap_pkg::side_t                    b_side_reg;
    logic [NW-1:0]                      b_num_reg;
    logic [cmap_pkg::SAMPLE_W-1:0]      b_den_reg;

    always_comb
    begin
        d        = 25'(req.sample_value) - 25'(range_min);
        r        = 25'(range_max) - 25'(range_min);
        zero     = (r == '0);
        in_range = !zero && (d != '0) && (d[cmap_pkg::SAMPLE_W] == r[cmap_pkg::SAMPLE_W]);
        ad       = d[cmap_pkg::SAMPLE_W] ? 24'(-d) : 24'(d);
        ar       = r[cmap_pkg::SAMPLE_W] ? 24'(-r) : 24'(r);

        ec = CW'(entry_count);
        if (ec < CW'(2))
        begin
            ec_clamped = CW'(2);
        end
        else if (ec > CW'(TABLE_DEPTH))
        begin
            ec_clamped = CW'(TABLE_DEPTH);
        end
        else
        begin
            ec_clamped = ec;
        end
        em1 = AW'(ec_clamped - CW'(1));

        side_next.cmd         = req.cmd;
        side_next.entry_index = req.entry_index;
        side_next.entry_red   = req.entry_red;
        side_next.entry_green = req.entry_green;
        side_next.entry_blue  = req.entry_blue;
        side_next.zero_range  = zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg     <= side_next;
            a_ad_reg       <= ad;
            a_ar_reg       <= ar;
            a_em1_reg      <= em1;
            a_in_range_reg <= in_range;
            b_side_reg     <= a_side_reg;
            b_num_reg      <= num_next;
            b_den_reg      <= den_next;
        end
    end

    // saturated: em1/1 gives the last entry; out of range: 0/1 gives entry 0
    always_comb
    begin
        prod = NW'(a_ad_reg) * NW'(a_em1_reg);
        sat  = (a_ad_reg >= a_ar_reg);
        if (!a_in_range_reg)
        begin
            num_next = '0;
            den_next = 24'd1;
        end
        else if (sat)
        begin
            num_next = NW'(a_em1_reg);
            den_next = 24'd1;
        end
        else
        begin
            num_next = prod;
            den_next = a_ar_reg;
        end
    end

    assign norm_valid = b_valid_reg;
    assign norm_side  = b_side_reg;
    assign norm_num   = b_num_reg;
    assign norm_den   = b_den_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_in_range_reg |-> a_ar_reg != '0)
        else $error("in-range request with zero divisor");

endmodule

// ----- hdl/cmap_div.sv -----
// ============================================================================
// cmap_div
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// ============================================================================
module cmap_div #(
    parameter int TABLE_DEPTH = cmap_pkg::TABLE_DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int NW = cmap_pkg::SAMPLE_W + AW,
    localparam int QW = AW + cmap_pkg::FRAC_W,
    localparam int DS = (QW + cmap_pkg::DIV_BITS - 1) / cmap_pkg::DIV_BITS,
    localparam int QP = DS * cmap_pkg::DIV_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          norm_valid,
    input  cmap_pkg::side_t               norm_side,
    input  logic [NW-1:0]                 norm_num,
    input  logic [cmap_pkg::SAMPLE_W-1:0] norm_den,
    output logic                          div_valid,
    output cmap_pkg::side_t               div_side,
    output logic [QP-1:0]                 div_quot
);

    localparam int RW = cmap_pkg::SAMPLE_W;

    logic [RW-1:0]         rem0;
    logic [QP-1:0]         lo0;
    logic [RW+QP-1:0]      step_next [DS];

    logic [DS-1:0]         valid_reg;
    cmap_pkg::side_t       side_reg [DS];
    logic [RW-1:0]         rem_reg  [DS];
    logic [RW-1:0]         den_reg  [DS];
    logic [QP-1:0]         lo_reg   [DS];

    // lo holds the dividend bits still to come on top, quotient bits below
    function automatic logic [RW+QP-1:0] div_step(input logic [RW-1:0] rem,
                                                  input logic [QP-1:0] lo,
                                                  input logic [RW-1:0] den);
        logic [RW:0]   t;
        logic [RW-1:0] rr;
        logic [QP-1:0] ll;
        logic          ge;
        rr = rem;
        ll = lo;
        for (int j = 0; j < cmap_pkg::DIV_BITS; j++)
        begin
            t  = {rr, ll[QP-1]};
            ge = (t >= {1'b0, den});
            rr = ge ? RW'(t - {1'b0, den}) : t[RW-1:0];
            ll = {ll[QP-2:0], ge};
        end
        return {rr, ll};
    endfunction

    assign rem0 = RW'(norm_num >> (QP - cmap_pkg::FRAC_W));
    assign lo0  = QP'({norm_num, {cmap_pkg::FRAC_W{1'b0}}});

    always_comb
    begin
        step_next[0] = div_step(rem0, lo0, norm_den);
        for (int k = 1; k < DS; k++)
        begin
            step_next[k] = div_step(rem_reg[k-1], lo_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg[0] <= norm_valid;
            for (int k = 1; k < DS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= norm_side;
            den_reg[0]  <= norm_den;
            for (int k = 1; k < DS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end
            for (int k = 0; k < DS; k++)
            begin
                rem_reg[k] <= step_next[k][QP +: RW];
                lo_reg[k]  <= step_next[k][QP-1:0];
            end
        end
    end

    assign div_valid = valid_reg[DS-1];
    assign div_side  = side_reg[DS-1];
    assign div_quot  = lo_reg[DS-1];

    assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid |-> (norm_num >> (QP - cmap_pkg::FRAC_W)) < NW'(norm_den))
        else $error("dividend high part not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> den_reg[0] != '0)
        else $error("zero divisor in divider");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DS-1] |-> rem_reg[DS-1] < den_reg[DS-1])
        else $error("final remainder not below divisor");

endmodule

// ----- hdl/cmap_mix.sv -----
// ============================================================================
// cmap_mix
// Table write and neighbor read, then per-channel blend into the result
// register.
// ============================================================================
module cmap_mix #(
    parameter int TABLE_DEPTH = cmap_pkg::TABLE_DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int QW = AW + cmap_pkg::FRAC_W,
    localparam int DS = (QW + cmap_pkg::DIV_BITS - 1) / cmap_pkg::DIV_BITS,
    localparam int QP = DS * cmap_pkg::DIV_BITS,
    localparam int XW = (AW > 10) ? AW + 1 : 11
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            div_valid,
    input  cmap_pkg::side_t div_side,
    input  logic [QP-1:0]   div_quot,
    output logic            rsp_valid,
    output cmap_pkg::rsp_t  rsp
);

    logic [AW-1:0]                 left;
    logic [AW-1:0]                 right;
    logic [cmap_pkg::FRAC_W-1:0]   frac;
    logic [XW-1:0]                 idx_ext;
    logic                          ram_we;
    logic [cmap_pkg::RGB_W-1:0]    left_rgb;
    logic [cmap_pkg::RGB_W-1:0]    right_rgb;

    logic                          m_valid_reg;
    logic [cmap_pkg::FRAC_W-1:0]   m_frac_reg;
    logic                          m_zero_reg;
    logic                          o_valid_reg;
    cmap_pkg::rsp_t                o_rsp_reg;
    cmap_pkg::rsp_t                rsp_next;

    always_comb
    begin
        left    = div_quot[cmap_pkg::FRAC_W +: AW];
        frac    = div_quot[cmap_pkg::FRAC_W-1:0];
        right   = left + AW'(frac != '0);
        idx_ext = XW'(div_side.entry_index);
        ram_we  = en && div_valid && (div_side.cmd == cmap_pkg::CMD_WRITE) &&
                  (idx_ext < XW'(TABLE_DEPTH));
    end

    cmap_ram #(
        .WIDTH (cmap_pkg::RGB_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (idx_ext[AW-1:0]),
        .wdata   ({div_side.entry_red, div_side.entry_green, div_side.entry_blue}),
        .re      (en),
        .raddr_a (left),
        .raddr_b (right),
        .rdata_a (left_rgb),
        .rdata_b (right_rgb)
    );

    always_comb
    begin
        rsp_next.out_red    = cmap_pkg::blend(left_rgb[23:16], right_rgb[23:16], m_frac_reg);
        rsp_next.out_green  = cmap_pkg::blend(left_rgb[15:8], right_rgb[15:8], m_frac_reg);
        rsp_next.out_blue   = cmap_pkg::blend(left_rgb[7:0], right_rgb[7:0], m_frac_reg);
        rsp_next.zero_range = m_zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= div_valid && (div_side.cmd == cmap_pkg::CMD_MAP);
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_frac_reg <= frac;
            m_zero_reg <= div_side.zero_range;
            o_rsp_reg  <= rsp_next;
        end
    end

    assign rsp_valid = o_valid_reg;
    assign rsp       = o_rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && (div_side.cmd == cmap_pkg::CMD_MAP) |->
        (div_quot >> cmap_pkg::FRAC_W) < QP'(TABLE_DEPTH - 1) ||
        ((div_quot >> cmap_pkg::FRAC_W) == QP'(TABLE_DEPTH - 1) && frac == '0))
        else $error("table position beyond last entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_zero_reg |-> m_frac_reg == '0)
        else $error("zero range with nonzero fraction");

endmodule

// ----- hdl/colormap_lerp_lookup_top.sv -----
// ============================================================================
// colormap_lerp_lookup_top
// Pipeline: two operand stages, the divider stages, table read, blend register.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits. Write requests update the table in its read stage and give no result.
// Reset clears the valid bits and loads the register defaults; the color
// table is not cleared and is undefined until written.
// ============================================================================
module colormap_lerp_lookup_top #(
    parameter int TABLE_DEPTH = cmap_pkg::TABLE_DEPTH_DEFAULT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int NW = cmap_pkg::SAMPLE_W + AW,
    localparam int QW = AW + cmap_pkg::FRAC_W,
    localparam int DS = (QW + cmap_pkg::DIV_BITS - 1) / cmap_pkg::DIV_BITS,
    localparam int QP = DS * cmap_pkg::DIV_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  cmap_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output cmap_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [cmap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmap_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic signed [cmap_pkg::SAMPLE_W-1:0] range_min_reg;
    logic signed [cmap_pkg::SAMPLE_W-1:0] range_max_reg;
    logic [cmap_pkg::COUNT_W-1:0]         entry_count_reg;

    logic                                 en;
    logic                                 norm_valid;
    cmap_pkg::side_t                      norm_side;
    logic [NW-1:0]                        norm_num;
    logic [cmap_pkg::SAMPLE_W-1:0]        norm_den;
    logic                                 div_valid;
    cmap_pkg::side_t                      div_side;
    logic [QP-1:0]                        div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= cmap_pkg::RANGE_MIN_RESET;
            range_max_reg   <= cmap_pkg::RANGE_MAX_RESET;
            entry_count_reg <= cmap_pkg::ENTRY_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmap_pkg::CFG_RANGE_MIN:   range_min_reg   <= cfg_data;
                cmap_pkg::CFG_RANGE_MAX:   range_max_reg   <= cfg_data;
                cmap_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[cmap_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    cmap_norm #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .req_valid   (req_valid),
        .req         (req),
        .range_min   (range_min_reg),
        .range_max   (range_max_reg),
        .entry_count (entry_count_reg),
        .norm_valid  (norm_valid),
        .norm_side   (norm_side),
        .norm_num    (norm_num),
        .norm_den    (norm_den)
    );

    cmap_div #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .norm_valid (norm_valid),
        .norm_side  (norm_side),
        .norm_num   (norm_num),
        .norm_den   (norm_den),
        .div_valid  (div_valid),
        .div_side   (div_side),
        .div_quot   (div_quot)
    );

    cmap_mix #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_valid (div_valid),
        .div_side  (div_side),
        .div_quot  (div_quot),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
